@@ sv/omrq_pkg.sv @@
// Package for the ordered match-and-remove queue.
// Holds the action codes, the entry and command types and the default depth.
// Used by omrq_cell and ordered_match_remove_queue_top.
package omrq_pkg;

	localparam int DEF_QUEUE_DEPTH = 16;

	localparam int NODE_W   = 12;
	localparam int TAG_W    = 16;
	localparam int HANDLE_W = 16;
	localparam int COUNT_W  = 5;

	typedef enum logic [1:0] {
		ACT_APPEND    = 2'd0,
		ACT_TAKE_NODE = 2'd1,
		ACT_TAKE_TAG  = 2'd2
	} action_t;

	typedef struct packed {
		logic [NODE_W-1:0]   node;
		logic [TAG_W-1:0]    tag;
		logic [HANDLE_W-1:0] handle;
	} entry_t;

	// Command broadcast to every cell for the word accepted in this cycle.
	typedef struct packed {
		logic   append;
		logic   take_node;
		logic   take_tag;
		entry_t data;
	} cell_cmd_t;

endpackage

@@ sv/omrq_cell.sv @@
// One slot of the queue: holds a valid bit and one entry.
// Compares against the search key, passes match and selected entry upward,
// and takes its upper neighbor's entry when a slot at or below it is removed.
// Depends on omrq_pkg.
module omrq_cell
	import omrq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cell_cmd_t cmd,
	input  logic      prev_valid,
	input  logic      found_in,
	input  entry_t    sel_in,
	input  logic      up_valid,
	input  entry_t    up_entry,
	output logic      valid,
	output entry_t    entry,
	output logic      found_out,
	output entry_t    sel_out
);

	logic   valid_q;
	entry_t entry_q;
	logic   match;
	logic   first;
	logic   shift;
	logic   load;

	always_comb begin
		match = 1'b0;
		if (valid_q) begin
			if (cmd.take_node)
				match = (entry_q.node == cmd.data.node);
			else if (cmd.take_tag)
				match = (entry_q.tag == cmd.data.tag);
		end
		first     = match && !found_in;
		found_out = found_in || match;
		sel_out   = first ? (sel_in | entry_q) : sel_in;
		// A removal at or below this slot pulls everything above down by one.
		shift     = (cmd.take_node || cmd.take_tag) && found_out;
		// The first free slot sits just above the last valid one.
		load      = cmd.append && !valid_q && prev_valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (shift)
			valid_q <= up_valid;
		else if (load)
			valid_q <= 1'b1;
	end

	always_ff @(posedge clk) begin
		if (shift)
			entry_q <= up_entry;
		else if (load)
			entry_q <= cmd.data;
	end

	assign valid = valid_q;
	assign entry = entry_q;

endmodule

@@ sv/ordered_match_remove_queue_top.sv @@
// Ordered match-and-remove queue, built as a row of slot cells.
// Uses the slot cells of omrq_cell and the types of omrq_pkg.
//
// Usage:
//   The input channel (in_valid, in_stall) carries one word: an action with
//   node_id, tag_value and msg_handle. Append puts the entry at the tail;
//   take by node or by tag removes the oldest entry whose node or tag equals
//   the key and closes the gap. The output channel (out_valid, out_stall)
//   returns one word per input word: hit, the removed entry's fields (zero
//   on a miss or append), stored_count and overflow (append on a full queue).
//   All slots compare against the key in the same cycle; the first-match
//   priority and the selected entry ripple up the row of cells, and the
//   shift-down happens at the same clock edge. An accepted word shows on the
//   output in the next cycle, and a new word is taken every cycle while the
//   output is not stalled, so the rate is one word per cycle.
//   While a result waits under out_stall, in_stall is high and the queue
//   holds its state. Reset empties the queue and drops any pending result;
//   no clearing pass is needed since only the valid bits are reset.
module ordered_match_remove_queue_top
	import omrq_pkg::*;
#(
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          action,
	input  logic [NODE_W-1:0]   node_id,
	input  logic [TAG_W-1:0]    tag_value,
	input  logic [HANDLE_W-1:0] msg_handle,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                hit,
	output logic [NODE_W-1:0]   out_node,
	output logic [TAG_W-1:0]    out_tag,
	output logic [HANDLE_W-1:0] out_handle,
	output logic [COUNT_W-1:0]  stored_count,
	output logic                overflow
);

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic          accept;
	logic          full;
	cell_cmd_t     cmd;
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_next;
	logic          ovf_next;

	logic   valid_vec [QUEUE_DEPTH+1];
	entry_t entry_vec [QUEUE_DEPTH+1];
	logic   found_vec [QUEUE_DEPTH+1];
	entry_t sel_vec   [QUEUE_DEPTH+1];
	logic   prev_vec  [QUEUE_DEPTH];

	logic                 out_valid_q;
	logic                 hit_q;
	entry_t               res_q;
	logic [CW-1:0]        count_res_q;
	logic                 ovf_q;
	logic [CW+COUNT_W-1:0] count_wide;

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;
	assign full     = (count_q == CW'(QUEUE_DEPTH));

	always_comb begin
		cmd.append    = 1'b0;
		cmd.take_node = 1'b0;
		cmd.take_tag  = 1'b0;
		cmd.data.node   = node_id;
		cmd.data.tag    = tag_value;
		cmd.data.handle = msg_handle;
		if (accept) begin
			unique case (action)
				ACT_APPEND:    cmd.append    = 1'b1;
				ACT_TAKE_NODE: cmd.take_node = 1'b1;
				ACT_TAKE_TAG:  cmd.take_tag  = 1'b1;
				default:       ;
			endcase
		end
	end

	assign found_vec[0]           = 1'b0;
	assign sel_vec[0]             = '0;
	assign valid_vec[QUEUE_DEPTH] = 1'b0;
	assign entry_vec[QUEUE_DEPTH] = '0;

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_first
			assign prev_vec[i] = 1'b1;
		end else begin : g_rest
			assign prev_vec[i] = valid_vec[i-1];
		end

		omrq_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.prev_valid(prev_vec[i]),
			.found_in  (found_vec[i]),
			.sel_in    (sel_vec[i]),
			.up_valid  (valid_vec[i+1]),
			.up_entry  (entry_vec[i+1]),
			.valid     (valid_vec[i]),
			.entry     (entry_vec[i]),
			.found_out (found_vec[i+1]),
			.sel_out   (sel_vec[i+1])
		);
	end

	always_comb begin
		count_next = count_q;
		ovf_next   = 1'b0;
		if (cmd.append) begin
			if (full)
				ovf_next = 1'b1;
			else
				count_next = count_q + CW'(1);
		end else if (found_vec[QUEUE_DEPTH]) begin
			count_next = count_q - CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept)
				count_q <= count_next;
			if (accept)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hit_q       <= found_vec[QUEUE_DEPTH];
			res_q       <= sel_vec[QUEUE_DEPTH];
			count_res_q <= count_next;
			ovf_q       <= ovf_next;
		end
	end

	// The count is shown masked to the width of the port.
	assign count_wide = {{COUNT_W{1'b0}}, count_res_q};

	assign out_valid    = out_valid_q;
	assign hit          = hit_q;
	assign out_node     = res_q.node;
	assign out_tag      = res_q.tag;
	assign out_handle   = res_q.handle;
	assign stored_count = count_wide[COUNT_W-1:0];
	assign overflow     = ovf_q;

endmodule
